### src/padded_argument_deframer_defines.svh
// ----------------------------------------------------------------------------
// padded argument deframer assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PADDED_ARGUMENT_DEFRAMER_DEFINES_SVH
`define PADDED_ARGUMENT_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PADF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("padded argument deframer: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define PADF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("padded argument deframer: next-cycle check failed");

`endif

### src/pad_dfr_pkg.sv
// ----------------------------------------------------------------------------
// pad_dfr_pkg
// types and constants shared by the padded argument deframer
// ----------------------------------------------------------------------------
package pad_dfr_pkg;

  // role of each byte in the argument area
  typedef enum logic [2:0] {
    KIND_LEN_LO  = 3'd0,
    KIND_LEN_HI  = 3'd1,
    KIND_KEPT    = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_PAD     = 3'd4,
    KIND_PAST    = 3'd5
  } byte_kind_e;

  // reset value of the copy limit
  localparam logic [15:0] MaxLenReset = 16'hFFFF;
  // bytes taken by the length field
  localparam logic [1:0] LenFieldBytes = 2'd2;

  // one input item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_packet;
    logic [15:0] arg_count;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    byte_kind_e  byte_kind;
    logic [15:0] arg_index;
    logic [15:0] arg_length;
    logic [15:0] payload_offset;
    logic        arg_end;
  } result_t;

endpackage

### src/pad_dfr_parser.sv
// ----------------------------------------------------------------------------
// pad_dfr_parser
// argument walk state and per-byte classification, one byte per step
// ----------------------------------------------------------------------------
module pad_dfr_parser import pad_dfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] max_len_i,
  output result_t     res_o
);

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_LEN_LO  = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_PAD     = 6'b010000,
    PH_PAST    = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] args_total_q, args_total_d;
  logic [15:0] args_done_q, args_done_d;
  logic [7:0]  length_low_q, length_low_d;
  logic [15:0] cur_length_q, cur_length_d;
  logic [15:0] byte_offset_q, byte_offset_d;
  logic [1:0]  pad_left_q, pad_left_d;

  // effective state after a packet start is applied
  phase_e      ph;
  logic [15:0] total, done, cur_len, offset;
  logic [7:0]  len_lo;
  logic [1:0]  pad;
  logic [15:0] new_len, offset_inc, done_inc;
  logic [1:0]  pad_dec;

  // classification and next state
  always_comb begin
    ph      = phase_q;
    total   = args_total_q;
    done    = args_done_q;
    cur_len = cur_length_q;
    offset  = byte_offset_q;
    len_lo  = length_low_q;
    pad     = pad_left_q;
    if (item_i.start_packet) begin
      total   = item_i.arg_count;
      done    = 16'd0;
      cur_len = 16'd0;
      offset  = 16'd0;
      len_lo  = 8'd0;
      pad     = 2'd0;
      ph      = (item_i.arg_count == 16'd0) ? PH_PAST : PH_LEN_LO;
    end

    new_len    = {item_i.data_byte, len_lo};
    offset_inc = offset + 16'd1;
    done_inc   = done + 16'd1;
    pad_dec    = pad - 2'd1;

    phase_d       = ph;
    args_total_d  = total;
    args_done_d   = done;
    length_low_d  = len_lo;
    cur_length_d  = cur_len;
    byte_offset_d = offset;
    pad_left_d    = pad;

    res_o.out_byte       = item_i.data_byte;
    res_o.byte_kind      = KIND_PAST;
    res_o.arg_index      = done;
    res_o.arg_length     = 16'd0;
    res_o.payload_offset = 16'd0;
    res_o.arg_end        = 1'b0;

    unique case (ph)
      PH_LEN_LO: begin
        res_o.byte_kind = KIND_LEN_LO;
        length_low_d    = item_i.data_byte;
        phase_d         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        res_o.byte_kind  = KIND_LEN_HI;
        res_o.arg_length = new_len;
        cur_length_d     = new_len;
        // pad so that length field plus payload is a multiple of four
        pad_left_d       = 2'd0 - (new_len[1:0] + LenFieldBytes);
        byte_offset_d    = 16'd0;
        phase_d          = (new_len != 16'd0) ? PH_PAYLOAD : PH_PAD;
      end
      PH_PAYLOAD: begin
        res_o.byte_kind      = (offset < max_len_i) ? KIND_KEPT : KIND_DROPPED;
        res_o.arg_length     = cur_len;
        res_o.payload_offset = offset;
        byte_offset_d        = offset_inc;
        if (offset_inc >= cur_len) begin
          if (pad != 2'd0) begin
            phase_d = PH_PAD;
          end else begin
            res_o.arg_end = 1'b1;
            args_done_d   = done_inc;
            phase_d       = (done_inc >= total) ? PH_PAST : PH_LEN_LO;
          end
        end
      end
      PH_PAD: begin
        res_o.byte_kind  = KIND_PAD;
        res_o.arg_length = cur_len;
        pad_left_d       = pad_dec;
        if (pad_dec == 2'd0) begin
          res_o.arg_end = 1'b1;
          args_done_d   = done_inc;
          phase_d       = (done_inc >= total) ? PH_PAST : PH_LEN_LO;
        end
      end
      PH_WAIT, PH_PAST: begin
        res_o.byte_kind = KIND_PAST;
      end
      default: begin
        res_o.byte_kind = KIND_PAST;
      end
    endcase
  end

  // state registers, updated only when a byte moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT;
      args_total_q  <= 16'd0;
      args_done_q   <= 16'd0;
      length_low_q  <= 8'd0;
      cur_length_q  <= 16'd0;
      byte_offset_q <= 16'd0;
      pad_left_q    <= 2'd0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      args_total_q  <= args_total_d;
      args_done_q   <= args_done_d;
      length_low_q  <= length_low_d;
      cur_length_q  <= cur_length_d;
      byte_offset_q <= byte_offset_d;
      pad_left_q    <= pad_left_d;
    end
  end

endmodule

### src/padded_argument_deframer.sv
// ----------------------------------------------------------------------------
// padded_argument_deframer
// tags each byte of a packet argument area with its role and position
// ----------------------------------------------------------------------------
// The slave stream carries one raw byte per item, with the packet start flag
// in tuser and the argument count beside the byte in tdata. The master stream
// returns the byte with its kind in tuser, its argument index, argument
// length and payload offset in tdata, and tlast on the final byte of each
// argument, padding included.
// Throughput is one item per cycle while the receiver takes results. An
// accepted item is held in the input register, then the single-pass
// classifier writes its result into the result register, from which the
// receiver takes it.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; tready then drops until the result is
// taken. Reset empties both registers, returns the walk to waiting for a
// packet start and sets max_len to 65535. Bytes before any start are tagged
// past last argument. cfg_we_i loads max_len; write it while the block idles.
// ----------------------------------------------------------------------------
module padded_argument_deframer import pad_dfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_len
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // data_byte[7:0], arg_count[23:8]
  input  logic        s_axis_tuser_i,   // start_packet
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_byte[7:0], arg_index[23:8], arg_length[39:24], payload_offset[55:40]
  output logic [55:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // byte_kind[2:0]
  output logic        m_axis_tlast_o    // arg_end
);

  logic [15:0] max_len_q;
  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  result_t     out_res_q;
  result_t     res;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // handshake between the two register stages
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // copy limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.data_byte    <= s_axis_tdata_i[7:0];
      in_item_q.arg_count    <= s_axis_tdata_i[23:8];
      in_item_q.start_packet <= s_axis_tuser_i;
    end
  end

  // classifier and walk state
  pad_dfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_item_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  // result packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.payload_offset, out_res_q.arg_length,
                            out_res_q.arg_index, out_res_q.out_byte};
  assign m_axis_tuser_o  = out_res_q.byte_kind;
  assign m_axis_tlast_o  = out_res_q.arg_end;

endmodule

### src/pad_dfr_checker.sv
// ----------------------------------------------------------------------------
// pad_dfr_checker
// port-level checks on the deframer result stream
// ----------------------------------------------------------------------------
`include "padded_argument_deframer_defines.svh"

module pad_dfr_checker import pad_dfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_i,
  input logic [2:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  logic kind_payload;
  logic kind_pad;
  logic kind_past;

  assign kind_payload = (m_axis_tuser_i == KIND_KEPT) || (m_axis_tuser_i == KIND_DROPPED);
  assign kind_pad     = (m_axis_tuser_i == KIND_PAD);
  assign kind_past    = (m_axis_tuser_i == KIND_PAST);

  // an argument only ends on a payload or pad byte
  `PADF_ASSERT_IMPLY(a_end_on_body, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tlast_i, kind_payload || kind_pad)

  // bytes past the last argument carry no length, offset or end mark
  `PADF_ASSERT_IMPLY(a_past_clean, clk_i, rst_ni, m_axis_tvalid_i && kind_past, (m_axis_tdata_i[55:24] == 32'd0) && !m_axis_tlast_i)

  // offset is zero on every byte that is not payload
  `PADF_ASSERT_IMPLY(a_offset_payload_only, clk_i, rst_ni, m_axis_tvalid_i && !kind_payload, m_axis_tdata_i[55:40] == 16'd0)

  // a stalled result holds
  `PADF_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

endmodule

bind padded_argument_deframer pad_dfr_checker u_pad_dfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
